// ===== src/urb_pkg.sv =====
// Shared types, codes and trigger tables for the UART register block.
package urb_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_NONE  = 2'd3
  } urb_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } urb_state_e;

  // register offsets
  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  // IIR source codes, bits 3:1
  localparam logic [2:0] IIR_NONE = 3'b000;
  localparam logic [2:0] IIR_THRE = 3'b001;
  localparam logic [2:0] IIR_RX   = 3'b010;

  localparam logic [7:0] LSR_BASE = 8'h60;

  typedef logic [5:0] urb_trig_t;
  localparam urb_trig_t TRIG16 [4] = '{6'd1, 6'd4, 6'd8, 6'd14};
  localparam urb_trig_t TRIG64 [4] = '{6'd1, 6'd16, 6'd32, 6'd56};

  function automatic urb_trig_t trig_level(input logic sel64, input logic [1:0] lvl);
    trig_level = sel64 ? TRIG64[lvl] : TRIG16[lvl];
  endfunction

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] line_byte;
    logic       link_present;
  } urb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
  } urb_out_t;

  // FIFO control from the register file
  typedef struct packed {
    logic rd_en;    // register a read this cycle
    logic rd_prev;  // read the entry before head instead of head
    logic push;
    logic pop;
    logic clear;
  } urb_fifo_ctrl_t;

endpackage

// ===== src/uart_register_block_with_rx_fifo.sv =====
// Top level: 16550-style register file around a receive FIFO.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction
//   per bus read, bus write or byte received from the line. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one result per
//   transaction: read data, a transmitted byte flag and the interrupt line.
// Timing
//   A transaction is accepted in the idle state, when the FIFO memory read is
//   launched; the next cycle executes it and loads the output register.
//   The result is registered in the output register; no new transaction is
//   taken while one executes, so each finishes before the next is accepted.
//   The FIFO memory read is registered, so execution has a state of its own.
// Reset
//   Register file, FIFO pointers and handshake state clear; payload registers
//   and FIFO memory contents are not cleared and hold nothing valid until written.
// Back-pressure
//   While a result waits under out_stall_i, the next transaction is held off
//   via in_stall_o; it is taken in the cycle the waiting result leaves.
module uart_register_block_with_rx_fifo import urb_pkg::*; #(
  parameter int RX_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  urb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output urb_out_t out_data_o
);

  localparam int PW = $clog2(RX_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(RX_DEPTH - 1);

  urb_state_e     st_q, st_d;
  urb_in_t        item_q;
  urb_out_t       out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  // register file
  logic [7:0] ier_q, ier_d, lcr_q, lcr_d, mcr_q, mcr_d, fcr_q, fcr_d;
  logic [7:0] dll_q, dll_d, dlm_q, dlm_d, scr_q, scr_d;
  logic       tep_q, tep_d;   // THR empty interrupt pending

  urb_fifo_ctrl_t fifo_ctrl;
  logic [7:0]     fifo_rdata;
  logic [PW-1:0]  count, count_n;
  logic           dlab;
  logic [7:0]     iir_cur;

  function automatic logic [2:0] irq_src(input logic [7:0] ier, input logic [7:0] fcr,
                                         input logic [PW-1:0] cnt, input logic tep);
    logic rx_cond;
    rx_cond = fcr[0] ? (cnt >= PW'(trig_level(fcr[5], fcr[7:6]))) : (cnt != '0);
    if (ier[0] && rx_cond)   irq_src = IIR_RX;
    else if (ier[1] && tep)  irq_src = IIR_THRE;
    else                     irq_src = IIR_NONE;
  endfunction

  urb_rx_fifo #(.RX_DEPTH(RX_DEPTH)) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i (item_q.cmd == CMD_LINE ? item_q.line_byte : item_q.write_data),
    .rdata_o (fifo_rdata),
    .count_o (count)
  );

  assign dlab   = lcr_q[7];
  assign accept = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (accept) st_d = ST_EXEC;
      ST_EXEC: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // handshake output: input stall
  always_comb begin
    in_stall_o = 1'b1;
    case (st_q)
      ST_IDLE: in_stall_o = out_valid_q && out_stall_i;
      ST_EXEC: in_stall_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign iir_cur = {{2{fcr_q[0]}}, fcr_q[0] & fcr_q[5], 1'b0,
                    irq_src(ier_q, fcr_q, count, tep_q),
                    irq_src(ier_q, fcr_q, count, tep_q) == IIR_NONE};

  // execute: register file update and result
  always_comb begin
    ier_d = ier_q; lcr_d = lcr_q; mcr_d = mcr_q; fcr_d = fcr_q;
    dll_d = dll_q; dlm_d = dlm_q; scr_d = scr_q; tep_d = tep_q;
    out_d = '0;
    fifo_ctrl = '0;
    // read is launched at acceptance; RBR on an empty FIFO repeats the previous entry
    fifo_ctrl.rd_en   = accept;
    fifo_ctrl.rd_prev = (count == '0);
    if (st_q == ST_EXEC) begin
      case (urb_cmd_e'(item_q.cmd))
        CMD_READ: begin
          case (item_q.reg_addr)
            REG_RBR_THR: begin
              if (dlab) begin
                out_d.read_data = dll_q;
              end else begin
                out_d.read_data = fifo_rdata;
                fifo_ctrl.pop   = (count != '0);
              end
            end
            REG_IER:     out_d.read_data = dlab ? dlm_q : ier_q;
            REG_IIR_FCR: begin
              out_d.read_data = iir_cur;
              if (iir_cur[3:1] == IIR_THRE) tep_d = 1'b0;
            end
            REG_LCR:     out_d.read_data = lcr_q;
            REG_MCR:     out_d.read_data = mcr_q;
            REG_LSR:     out_d.read_data = LSR_BASE | {7'd0, count != '0};
            REG_MSR:     out_d.read_data = {item_q.link_present, 7'd0};
            REG_SCR:     out_d.read_data = scr_q;
            default:     out_d.read_data = '0;
          endcase
        end
        CMD_WRITE: begin
          case (item_q.reg_addr)
            REG_RBR_THR: begin
              if (dlab) begin
                dll_d = item_q.write_data;
              end else begin
                tep_d = 1'b1;
                if (mcr_q[4]) begin
                  fifo_ctrl.push = 1'b1;   // loopback into receive FIFO
                end else if (item_q.link_present) begin
                  out_d.tx_valid = 1'b1;
                  out_d.tx_byte  = item_q.write_data;
                end
              end
            end
            REG_IER: begin
              if (dlab) dlm_d = item_q.write_data;
              else      ier_d = item_q.write_data;
            end
            REG_IIR_FCR: begin
              fcr_d = item_q.write_data;
              fifo_ctrl.clear = (item_q.write_data[1:0] != 2'b00);
            end
            REG_LCR: lcr_d = item_q.write_data;
            REG_MCR: mcr_d = item_q.write_data;
            REG_SCR: scr_d = item_q.write_data;
            default: ;  // LSR and MSR are read only
          endcase
        end
        CMD_LINE: fifo_ctrl.push = item_q.link_present;
        default:  ;
      endcase
    end

    // count after this transaction, for the interrupt line
    if (fifo_ctrl.clear)                       count_n = '0;
    else if (fifo_ctrl.pop)                    count_n = count - 1'b1;
    else if (fifo_ctrl.push && count != LAST)  count_n = count + 1'b1;
    else                                       count_n = count;
    out_d.irq = (irq_src(ier_d, fcr_d, count_n, tep_d) != IIR_NONE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (st_q == ST_EXEC)             out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      ier_q <= '0; lcr_q <= '0; mcr_q <= '0; fcr_q <= '0;
      dll_q <= '0; dlm_q <= '0; scr_q <= '0; tep_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      ier_q <= ier_d; lcr_q <= lcr_d; mcr_q <= mcr_d; fcr_q <= fcr_d;
      dll_q <= dll_d; dlm_q <= dlm_d; scr_q <= scr_d; tep_q <= tep_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept)          item_q <= in_data_i;
    if (st_q == ST_EXEC) out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EXEC |=> st_q == ST_IDLE) else $error("execute state held");
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q == ST_EXEC && !out_valid_q) else $error("output slot busy");
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EXEC |=> out_valid_o) else $error("result not presented");

endmodule

// ===== src/urb_rx_fifo.sv =====
// Receive FIFO: byte memory with registered read and modular pointers.
module urb_rx_fifo import urb_pkg::*; #(
  parameter int RX_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  urb_fifo_ctrl_t              ctrl_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o,
  output logic [$clog2(RX_DEPTH)-1:0] count_o
);

  localparam int PW = $clog2(RX_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(RX_DEPTH - 1);

  logic [7:0]    rx_mem_q [RX_DEPTH];
  logic [7:0]    rdata_q;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PW-1:0] rd_addr;
  logic [PW:0]   diff;
  logic          push_ok;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign diff    = {1'b0, tail_q} - {1'b0, head_q}
                 + ((tail_q < head_q) ? (PW+1)'(RX_DEPTH) : '0);
  assign count_o = diff[PW-1:0];
  assign push_ok = ctrl_i.push && (count_o != LAST);
  assign rd_addr = ctrl_i.rd_prev ? ((head_q == '0) ? LAST : head_q - 1'b1) : head_q;
  assign rdata_o = rdata_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (ctrl_i.pop) head_d = ptr_inc(head_q);
      if (push_ok)    tail_d = ptr_inc(tail_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok && !ctrl_i.clear) rx_mem_q[tail_q] <= wdata_i;
    if (ctrl_i.rd_en) rdata_q <= rx_mem_q[rd_addr];
  end

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop)) else $error("push and pop together");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> count_o != '0) else $error("pop on empty FIFO");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> count_o == '0) else $error("FIFO not empty after clear");

endmodule

// ===== tb/sv/tb_uart_register_block_with_rx_fifo.sv =====
// Testbench for the UART register block: directed and random bus/line transactions, scoreboarded.
module tb_uart_register_block_with_rx_fifo import urb_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_DEPTH    = 64;
  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int REPORT_MAX  = 10;

  // rx trigger levels, indexed by FCR bit 5 then FCR bits 7:6
  localparam int RX_TRIGGER [2][4] = '{'{1, 4, 8, 14}, '{1, 16, 32, 56}};

  // ---------------------------------------------------------------------------
  // Register file tracker: mirrors the UART state, queues the reply each
  // accepted transaction should produce and checks replies in order.
  // ---------------------------------------------------------------------------
  class uart_regfile_tracker;
    logic [7:0]  rx_mem [RX_DEPTH];
    bit          rx_written [RX_DEPTH];
    int unsigned head = 0;
    int unsigned tail = 0;
    logic [7:0]  ier = '0, lcr = '0, mcr = '0, fcr = '0;
    logic [7:0]  dll = '0, dlm = '0, scr = '0;
    bit          thre_pend = 1'b0;
    urb_out_t    replies_due [$];
    int          mismatches = 0;

    function int unsigned fill_level();
      return (tail + RX_DEPTH - head) % RX_DEPTH;
    endfunction

    // a push into a FIFO holding depth-1 bytes is lost
    function void push_byte(logic [7:0] b);
      if (fill_level() >= RX_DEPTH - 1) return;
      rx_mem[tail]     = b;
      rx_written[tail] = 1'b1;
      tail             = (tail + 1) % RX_DEPTH;
    endfunction

    function logic [2:0] irq_src();
      bit rx_hit;
      if (!fcr[0]) rx_hit = (fill_level() != 0);
      else         rx_hit = (fill_level() >= RX_TRIGGER[fcr[5]][fcr[7:6]]);
      if (ier[0] && rx_hit)    return IIR_RX;
      if (ier[1] && thre_pend) return IIR_THRE;
      return IIR_NONE;
    endfunction

    function void note_transaction(urb_in_t it);
      urb_out_t   r;
      bit         dlab;
      logic [2:0] src;
      r    = '0;
      dlab = lcr[7];
      case (it.cmd)
        CMD_READ: begin
          case (it.reg_addr)
            REG_RBR_THR: begin
              if (dlab) begin
                r.read_data = dll;
              end else if (fill_level() == 0) begin
                // empty: repeat the byte just before head, no pop
                r.read_data = rx_mem[(head + RX_DEPTH - 1) % RX_DEPTH];
              end else begin
                r.read_data = rx_mem[head];
                head        = (head + 1) % RX_DEPTH;
              end
            end
            REG_IER:     r.read_data = dlab ? dlm : ier;
            REG_IIR_FCR: begin
              src         = irq_src();
              r.read_data = {fcr[0] ? 2'b11 : 2'b00, fcr[0] & fcr[5], 1'b0, src,
                             src == IIR_NONE};
              if (src == IIR_THRE) thre_pend = 1'b0;
            end
            REG_LCR:     r.read_data = lcr;
            REG_MCR:     r.read_data = mcr;
            REG_LSR:     r.read_data = LSR_BASE | {7'd0, fill_level() != 0};
            REG_MSR:     r.read_data = {it.link_present, 7'd0};
            default:     r.read_data = scr;
          endcase
        end
        CMD_WRITE: begin
          case (it.reg_addr)
            REG_RBR_THR: begin
              if (dlab) begin
                dll = it.write_data;
              end else begin
                thre_pend = 1'b1;
                if (mcr[4]) begin
                  push_byte(it.write_data);
                end else if (it.link_present) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = it.write_data;
                end
              end
            end
            REG_IER: if (dlab) dlm = it.write_data; else ier = it.write_data;
            REG_IIR_FCR: begin
              fcr = it.write_data;
              if (it.write_data[1:0] != 2'b00) begin
                head = 0;
                tail = 0;
              end
            end
            REG_LCR: lcr = it.write_data;
            REG_MCR: mcr = it.write_data;
            REG_SCR: scr = it.write_data;
            default: ;
          endcase
        end
        CMD_LINE: if (it.link_present) push_byte(it.line_byte);
        default: ;
      endcase
      r.irq = (irq_src() != IIR_NONE);
      replies_due.push_back(r);
    endfunction

    function void check_reply(urb_out_t got);
      urb_out_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] reply with nothing outstanding: rd=%h txv=%b txb=%h irq=%b",
                   $realtime, got.read_data, got.tx_valid, got.tx_byte, got.irq);
        return;
      end
      want = replies_due.pop_front();
      if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
          got.tx_byte !== want.tx_byte || got.irq !== want.irq) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] reply mismatch: exp rd=%h txv=%b txb=%h irq=%b, got rd=%h txv=%b txb=%h irq=%b",
                   $realtime, want.read_data, want.tx_valid, want.tx_byte, want.irq,
                   got.read_data, got.tx_valid, got.tx_byte, got.irq);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  urb_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  urb_out_t out_data;

  always #5 clk_i = ~clk_i;

  uart_register_block_with_rx_fifo #(
    .RX_DEPTH(RX_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  uart_regfile_tracker tracker;
  int src_idle_pct = 26;  // sender gap probability, percent
  int snk_idle_pct = 47;  // receiver stall probability, percent
  int items_done   = 0;   // transactions that do something
  int quiet_cycles = 0;

  // Receiver back-pressure: one decision per falling edge.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  // Monitor on the rising edge: note accepted transactions, check replies and
  // run the watchdog. Nothing here is sampled during reset.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) tracker.note_transaction(in_data);
      if (out_valid && !out_stall) tracker.check_reply(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("uart_register_block_with_rx_fifo verification failed");
        $finish;
      end
    end
  end

  function automatic urb_in_t mk(urb_cmd_e c, logic [2:0] a, logic [7:0] wd,
                                 logic [7:0] lb, logic lk);
    urb_in_t it;
    it.cmd          = c;
    it.reg_addr     = a;
    it.write_data   = wd;
    it.line_byte    = lb;
    it.link_present = lk;
    return it;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one transaction; entered and left at a falling edge. An RBR read
  // that would land on a never-written FIFO entry is turned into an LSR read,
  // as that entry holds nothing defined.
  task automatic issue(input urb_in_t it);
    if (it.cmd == CMD_READ && it.reg_addr == REG_RBR_THR && !tracker.lcr[7] &&
        tracker.fill_level() == 0 &&
        !tracker.rx_written[(tracker.head + RX_DEPTH - 1) % RX_DEPTH])
      it.reg_addr = REG_LSR;
    if (!(it.cmd == CMD_NONE || (it.cmd == CMD_LINE && !it.link_present) ||
          (it.cmd == CMD_WRITE && (it.reg_addr == REG_LSR || it.reg_addr == REG_MSR))))
      items_done++;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Directed opening: register extremes, DLAB bank, THR/THRE path, loopback,
  // empty RBR repeat, FCR clear and trigger modes, ignored writes.
  task automatic run_directed();
    issue(mk(CMD_READ,  REG_LSR,     8'h00, 8'h00, 1'b0)); // empty LSR
    issue(mk(CMD_READ,  REG_MSR,     8'hFF, 8'hFF, 1'b1)); // carrier detect up
    issue(mk(CMD_READ,  REG_MSR,     8'h00, 8'h00, 1'b0));
    issue(mk(CMD_READ,  REG_IIR_FCR, 8'h00, 8'h00, 1'b1)); // nothing pending
    issue(mk(CMD_WRITE, REG_SCR,     8'hFF, 8'h00, 1'b1));
    issue(mk(CMD_READ,  REG_SCR,     8'h00, 8'h00, 1'b1));
    issue(mk(CMD_WRITE, REG_LCR,     8'h80, 8'h00, 1'b1)); // DLAB on
    issue(mk(CMD_WRITE, REG_RBR_THR, 8'hFF, 8'h00, 1'b1));
    issue(mk(CMD_WRITE, REG_IER,     8'h00, 8'h00, 1'b1));
    issue(mk(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00, 1'b1));
    issue(mk(CMD_READ,  REG_IER,     8'h00, 8'h00, 1'b1));
    issue(mk(CMD_WRITE, REG_LCR,     8'h03, 8'h00, 1'b1)); // DLAB off
    issue(mk(CMD_WRITE, REG_IER,     8'h03, 8'h00, 1'b1));
    issue(mk(CMD_WRITE, REG_RBR_THR, 8'h00, 8'h00, 1'b1)); // THR out, THRE irq
    issue(mk(CMD_READ,  REG_IIR_FCR, 8'h00, 8'h00, 1'b1)); // reports THRE, clears
    issue(mk(CMD_WRITE, REG_RBR_THR, 8'hFF, 8'h00, 1'b0)); // no link: no tx
    issue(mk(CMD_LINE,  REG_RBR_THR, 8'h00, 8'h5A, 1'b1));
    issue(mk(CMD_LINE,  REG_RBR_THR, 8'h00, 8'hA5, 1'b0)); // dropped, no link
    issue(mk(CMD_READ,  REG_LSR,     8'h00, 8'h00, 1'b1)); // data ready
    issue(mk(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00, 1'b1)); // pop
    issue(mk(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00, 1'b1)); // empty: repeat
    issue(mk(CMD_WRITE, REG_MCR,     8'h10, 8'h00, 1'b1)); // loopback
    issue(mk(CMD_WRITE, REG_RBR_THR, 8'h3C, 8'h00, 1'b1));
    issue(mk(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00, 1'b1));
    issue(mk(CMD_WRITE, REG_MCR,     8'h00, 8'h00, 1'b1));
    issue(mk(CMD_WRITE, REG_IIR_FCR, 8'hC7, 8'h00, 1'b1)); // FIFO on, clear
    issue(mk(CMD_WRITE, REG_IIR_FCR, 8'hE1, 8'h00, 1'b1)); // 64-byte table
    issue(mk(CMD_WRITE, REG_LSR,     8'hFF, 8'h00, 1'b1)); // ignored
    issue(mk(CMD_WRITE, REG_MSR,     8'hFF, 8'h00, 1'b1)); // ignored
    issue(mk(CMD_NONE,  REG_SCR,     8'hFF, 8'hFF, 1'b1)); // no effect
  endtask

  // Random traffic: mostly well-formed sequences (line bursts, drains,
  // loopback runs, config writes, status polls) plus fully random noise.
  task automatic run_random(input int target);
    int kind;
    int n;
    int k;
    logic [7:0] v;
    while (items_done < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // line burst; the long ones fill the FIFO and overrun it
        n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 8);
        for (k = 0; k < n; k++)
          issue(mk(CMD_LINE, 3'($urandom_range(0, 7)), rnd8(), rnd8(),
                   $urandom_range(0, 15) != 0));
      end else if (kind < 55) begin
        // drain, occasionally reading past empty
        n = tracker.fill_level() + $urandom_range(0, 2);
        for (k = 0; k < n; k++)
          issue(mk(CMD_READ, REG_RBR_THR, rnd8(), rnd8(), 1'($urandom_range(0, 1))));
      end else if (kind < 65) begin
        // loopback run
        v = rnd8();
        issue(mk(CMD_WRITE, REG_MCR, v | 8'h10, rnd8(), 1'($urandom_range(0, 1))));
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          issue(mk(CMD_WRITE, REG_RBR_THR, rnd8(), rnd8(), 1'($urandom_range(0, 1))));
        issue(mk(CMD_WRITE, REG_MCR, v & 8'hEF, rnd8(), 1'($urandom_range(0, 1))));
      end else if (kind < 75) begin
        // configuration writes; DLAB set only now and then
        case ($urandom_range(0, 4))
          0: issue(mk(CMD_WRITE, REG_IIR_FCR, rnd8(), rnd8(), 1'($urandom_range(0, 1))));
          1: issue(mk(CMD_WRITE, REG_IER, rnd8(), rnd8(), 1'($urandom_range(0, 1))));
          2: issue(mk(CMD_WRITE, REG_LCR, {$urandom_range(0, 4) == 0, 7'($urandom_range(0, 127))},
                      rnd8(), 1'($urandom_range(0, 1))));
          3: issue(mk(CMD_WRITE, REG_SCR, rnd8(), rnd8(), 1'($urandom_range(0, 1))));
          default: issue(mk(CMD_WRITE, REG_MCR, rnd8(), rnd8(), 1'($urandom_range(0, 1))));
        endcase
      end else if (kind < 90) begin
        // status and register polls
        issue(mk(CMD_READ, 3'($urandom_range(0, 7)), rnd8(), rnd8(),
                 1'($urandom_range(0, 1))));
      end else begin
        issue(mk(urb_cmd_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rnd8(),
                 rnd8(), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random(700);

    // swap the idle pattern: sender idles more, receiver stalls less
    src_idle_pct = 47;
    snk_idle_pct = 26;
    run_random(1400);

    // back to back on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(2000);
    in_valid <= 1'b0;

    while (tracker.replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
      $display("uart_register_block_with_rx_fifo verification clean");
    else
      $display("uart_register_block_with_rx_fifo verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/urb_pkg.sv
src/urb_rx_fifo.sv
src/uart_register_block_with_rx_fifo.sv
tb/sv/tb_uart_register_block_with_rx_fifo.sv
